>>> sv/rmaf_pkg.sv
// ----------------------------------------------------------------------------
// rmaf_pkg
// Shared constants and types of the robust moving-average filter.
// ----------------------------------------------------------------------------
package rmaf_pkg;

  // Configuration register file
  localparam int          APB_ADDR_W  = 3;
  localparam int          APB_DATA_W  = 32;
  localparam int          REG_IDX_LSB = 2;
  localparam logic        REG_TRUST_GAIN = 1'b0;

  // Trust gain register
  localparam int          TRUST_W     = 4;
  localparam logic [3:0]  TRUST_RESET = 4'd6;

  // Status of the shared divider
  typedef struct packed {
    logic busy;
    logic done;
  } rmaf_div_status_t;

endpackage

>>> sv/rmaf_if.sv
// ----------------------------------------------------------------------------
// rmaf_if
// Valid/ready channels of the robust moving-average filter.
// ----------------------------------------------------------------------------
interface rmaf_in_if #(
  parameter int SAMPLE_WIDTH = 32
);
  logic                    valid;
  logic                    ready;
  logic [SAMPLE_WIDTH-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface rmaf_out_if #(
  parameter int SAMPLE_WIDTH = 32
);
  logic                    valid;
  logic                    ready;
  logic [SAMPLE_WIDTH-1:0] smoothed;
  logic                    rejected;

  modport source (output valid, output smoothed, output rejected, input ready);
  modport sink   (input valid, input smoothed, input rejected, output ready);
endinterface

>>> sv/robust_moving_average_filter.sv
// ----------------------------------------------------------------------------
// robust_moving_average_filter
// Moving average of signed Q16.16 samples with median-residual outlier
// rejection, built around a small sequencer and one shared divider.
// ----------------------------------------------------------------------------
// Each item carries one signed sample. The filter keeps the last WINDOW-1
// samples with their absolute residuals and keep flags. A new item is averaged
// with the kept history (division truncates toward zero), its residual
// |sample - mean| is compared against the trust gain times the median residual
// of the window, and the item is rejected when the residual is strictly
// larger. The result is the mean of the kept samples (zero when none are
// kept) plus the rejected flag, and the window then advances by one slot.
// The trust gain register sits at APB byte address 0, resets to 6 and must
// only be written while the filter is idle. The filter handles one item at a
// time and takes no new item until the previous one has passed its finishing
// step. A rejected item occupies it longer than a kept one, since it needs a
// second pass of the bit-serial divider for its mean. The median sweep runs one
// compare per cycle, testing each residual against every other one. A finished
// result waits in an output register, so a new item is taken while the
// previous result is still unclaimed; the filter only holds in its last
// state if a second result finishes before the first one is taken.
// ----------------------------------------------------------------------------
module robust_moving_average_filter
  import rmaf_pkg::*;
#(
  parameter int WINDOW       = 3,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  rmaf_in_if.sink               in_i,
  rmaf_out_if.source            out_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int SW      = SAMPLE_WIDTH;
  localparam int HIST    = WINDOW - 1;
  localparam int CNT_W   = $clog2(WINDOW + 1);
  localparam int SUM_W   = SW + CNT_W;
  localparam int RES_W   = SW + 1;
  localparam int PROD_W  = RES_W + TRUST_W;
  localparam int HIDX_W  = $clog2(HIST);
  localparam int MIDX_W  = $clog2(WINDOW);
  localparam int RANK_LO = (WINDOW - 1) / 2;
  localparam int RANK_HI = WINDOW / 2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SUM,
    S_DIV1,
    S_WAIT1,
    S_RES,
    S_MED_LOAD,
    S_MED_CMP,
    S_MED_NEXT,
    S_MUL,
    S_CMP,
    S_DIV2,
    S_WAIT2,
    S_OUT
  } state_e;

  state_e              state_q;

  // Configuration
  logic [TRUST_W-1:0]  tf_q;
  logic                reg_sel;

  // Window history (oldest in slot 0)
  logic [SW-1:0]       hist_smp_q [HIST];
  logic [RES_W-1:0]    hist_res_q [HIST];
  logic [HIST-1:0]     hist_wgt_q;

  // Item working registers
  logic [SW-1:0]       smp_q;
  logic [SUM_W-1:0]    hsum_q;
  logic [CNT_W-1:0]    hcnt_q;
  logic [HIDX_W-1:0]   sum_idx_q;
  logic [SW-1:0]       mean_q;
  logic [RES_W-1:0]    res_q;
  logic [RES_W-1:0]    work_q [WINDOW];
  logic [RES_W-1:0]    work_rot [WINDOW];
  logic [RES_W-1:0]    cand_q;
  logic [CNT_W-1:0]    less_q;
  logic [CNT_W-1:0]    leq_q;
  logic [MIDX_W-1:0]   med_i_q;
  logic [MIDX_W-1:0]   med_j_q;
  logic [RES_W-1:0]    lo_q;
  logic [RES_W-1:0]    hi_q;
  logic [PROD_W-1:0]   prod_q;
  logic                rej_q;

  // Output register
  logic                out_valid_q;
  logic [SW-1:0]       out_smp_q;
  logic                out_rej_q;

  // Datapath
  logic [SUM_W-1:0]    acc_add;
  logic [SUM_W-1:0]    smp_ext;
  logic                div_start;
  logic [SUM_W-1:0]    div_num;
  logic [CNT_W-1:0]    div_den;
  logic [SW-1:0]       div_quo;
  rmaf_div_status_t    div_status;
  logic [RES_W-1:0]    diff;
  logic [RES_W-1:0]    res_abs;
  logic [RES_W:0]      med_sum;
  logic [RES_W-1:0]    med;
  logic [PROD_W-1:0]   prod_d;
  logic                rej_d;
  logic                out_free;
  logic                cmp_lt;
  logic                cmp_le;
  logic                lo_hit;
  logic                hi_hit;

  // --------------------------------------------------------------------------
  // Configuration port: single trust gain register, zero wait states
  // --------------------------------------------------------------------------
  assign reg_sel = (paddr[APB_ADDR_W-1:REG_IDX_LSB] == REG_TRUST_GAIN);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? APB_DATA_W'(tf_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tf_q <= TRUST_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      tf_q <= pwdata[TRUST_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Handshake
  // --------------------------------------------------------------------------
  assign in_i.ready     = (state_q == S_IDLE);
  assign out_o.valid    = out_valid_q;
  assign out_o.smoothed = out_smp_q;
  assign out_o.rejected = out_rej_q;
  assign out_free       = !out_valid_q || out_o.ready;

  // --------------------------------------------------------------------------
  // Arithmetic shared across the sequence
  // --------------------------------------------------------------------------
  assign acc_add = {{CNT_W{hist_smp_q[sum_idx_q][SW-1]}}, hist_smp_q[sum_idx_q]};
  assign smp_ext = {{CNT_W{smp_q[SW-1]}}, smp_q};

  // First mean includes the new sample; the second only runs after a
  // rejection and covers the kept history alone (divisor forced to one if
  // nothing is kept, which leaves a zero sum as zero).
  assign div_start = (state_q == S_DIV1) || (state_q == S_DIV2);
  assign div_num   = (state_q == S_DIV1) ? (hsum_q + smp_ext) : hsum_q;
  assign div_den   = (state_q == S_DIV1) ? (hcnt_q + CNT_W'(1)) :
                     ((hcnt_q == '0) ? CNT_W'(1) : hcnt_q);

  assign diff    = {smp_q[SW-1], smp_q} - {mean_q[SW-1], mean_q};
  assign res_abs = diff[RES_W-1] ? (~diff + RES_W'(1)) : diff;

  // Even windows average the two middle ranks; odd ones see lo == hi
  assign med_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign med     = med_sum[RES_W:1];
  assign prod_d  = PROD_W'(tf_q) * PROD_W'(med);
  assign rej_d   = ({{TRUST_W{1'b0}}, res_q} > prod_q);

  // Rank search: a candidate holds rank r when less <= r < less_or_equal
  assign cmp_lt = (work_q[0] < cand_q);
  assign cmp_le = (work_q[0] <= cand_q);
  assign lo_hit = (less_q <= CNT_W'(RANK_LO)) && (CNT_W'(RANK_LO) < leq_q);
  assign hi_hit = (less_q <= CNT_W'(RANK_HI)) && (CNT_W'(RANK_HI) < leq_q);

  always_comb begin
    for (int k = 0; k < WINDOW - 1; k++) begin
      work_rot[k] = work_q[k+1];
    end
    work_rot[WINDOW-1] = work_q[0];
  end

  rmaf_div #(
    .NUM_W (SUM_W),
    .DEN_W (CNT_W),
    .QUO_W (SW)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .num_i    (div_num),
    .den_i    (div_den),
    .quo_o    (div_quo),
    .status_o (div_status)
  );

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      hist_wgt_q  <= '1;
      for (int k = 0; k < HIST; k++) begin
        hist_smp_q[k] <= '0;
        hist_res_q[k] <= '0;
      end
      for (int k = 0; k < WINDOW; k++) begin
        work_q[k] <= '0;
      end
      smp_q       <= '0;
      hsum_q      <= '0;
      hcnt_q      <= '0;
      sum_idx_q   <= '0;
      mean_q      <= '0;
      res_q       <= '0;
      cand_q      <= '0;
      less_q      <= '0;
      leq_q       <= '0;
      med_i_q     <= '0;
      med_j_q     <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      prod_q      <= '0;
      rej_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_smp_q   <= '0;
      out_rej_q   <= 1'b0;
    end else begin
      // Drop the result once taken; the finishing step sets its own
      if (out_o.ready && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            smp_q     <= in_i.sample;
            hsum_q    <= '0;
            hcnt_q    <= '0;
            sum_idx_q <= '0;
            state_q   <= S_SUM;
          end
        end

        // Accumulate the kept history, one slot per cycle
        S_SUM: begin
          if (hist_wgt_q[sum_idx_q]) begin
            hsum_q <= hsum_q + acc_add;
            hcnt_q <= hcnt_q + CNT_W'(1);
          end
          if (sum_idx_q == HIDX_W'(HIST - 1)) begin
            state_q <= S_DIV1;
          end else begin
            sum_idx_q <= sum_idx_q + HIDX_W'(1);
          end
        end

        S_DIV1: begin
          state_q <= S_WAIT1;
        end

        S_WAIT1: begin
          if (div_status.done) begin
            mean_q  <= div_quo;
            state_q <= S_RES;
          end
        end

        // Store the residual and load the residual ring for the median
        S_RES: begin
          res_q <= res_abs;
          for (int k = 0; k < HIST; k++) begin
            work_q[k] <= hist_res_q[k];
          end
          work_q[HIST] <= res_abs;
          med_i_q      <= '0;
          state_q      <= S_MED_LOAD;
        end

        // Take the candidate at the head of the ring and count itself
        S_MED_LOAD: begin
          cand_q  <= work_q[0];
          work_q  <= work_rot;
          less_q  <= '0;
          leq_q   <= CNT_W'(1);
          med_j_q <= '0;
          state_q <= S_MED_CMP;
        end

        // Compare the candidate against every other residual
        S_MED_CMP: begin
          if (cmp_lt) begin
            less_q <= less_q + CNT_W'(1);
          end
          if (cmp_le) begin
            leq_q <= leq_q + CNT_W'(1);
          end
          work_q <= work_rot;
          if (med_j_q == MIDX_W'(WINDOW - 2)) begin
            state_q <= S_MED_NEXT;
          end else begin
            med_j_q <= med_j_q + MIDX_W'(1);
          end
        end

        // Latch the middle ranks and advance the ring to the next candidate
        S_MED_NEXT: begin
          if (lo_hit) begin
            lo_q <= cand_q;
          end
          if (hi_hit) begin
            hi_q <= cand_q;
          end
          work_q <= work_rot;
          if (med_i_q == MIDX_W'(WINDOW - 1)) begin
            state_q <= S_MUL;
          end else begin
            med_i_q <= med_i_q + MIDX_W'(1);
            state_q <= S_MED_LOAD;
          end
        end

        S_MUL: begin
          prod_q  <= prod_d;
          state_q <= S_CMP;
        end

        // A kept sample leaves the first mean unchanged
        S_CMP: begin
          rej_q   <= rej_d;
          state_q <= rej_d ? S_DIV2 : S_OUT;
        end

        S_DIV2: begin
          state_q <= S_WAIT2;
        end

        S_WAIT2: begin
          if (div_status.done) begin
            mean_q  <= div_quo;
            state_q <= S_OUT;
          end
        end

        // Publish the result and advance the window
        S_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_smp_q   <= mean_q;
            out_rej_q   <= rej_q;
            for (int k = 0; k < HIST - 1; k++) begin
              hist_smp_q[k] <= hist_smp_q[k+1];
              hist_res_q[k] <= hist_res_q[k+1];
              hist_wgt_q[k] <= hist_wgt_q[k+1];
            end
            hist_smp_q[HIST-1] <= smp_q;
            hist_res_q[HIST-1] <= res_q;
            hist_wgt_q[HIST-1] <= !rej_q;
            state_q            <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_busy_after_accept: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready
  ) else $error("filter ready again right after taking an item");

  a_result_from_finish: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_OUT)
  ) else $error("result raised outside the finishing step");

  a_rank_counts: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MED_NEXT) |-> (leq_q > less_q)
  ) else $error("median rank counts inconsistent");

  a_reject_nonzero: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_OUT) && rej_q) |-> (res_q != '0)
  ) else $error("rejection with a zero residual");

  a_div_start_idle: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_status.busy
  ) else $error("divider started while busy");

endmodule

>>> sv/rmaf_div.sv
// ----------------------------------------------------------------------------
// rmaf_div
// Bit-serial restoring divider: signed dividend by a small unsigned divisor,
// quotient truncated toward zero, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rmaf_div
  import rmaf_pkg::*;
#(
  parameter int NUM_W = 34,
  parameter int DEN_W = 2,
  parameter int QUO_W = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [QUO_W-1:0] quo_o,
  output rmaf_div_status_t status_o
);

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] step_q;
  logic              neg_q;
  logic [NUM_W-1:0]  mag_q;
  logic [DEN_W-1:0]  rem_q;
  logic [DEN_W-1:0]  den_q;

  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;
  logic              fits;
  logic [NUM_W-1:0]  quo_full;

  assign trial    = {rem_q, mag_q[NUM_W-1]};
  assign diff     = trial - {1'b0, den_q};
  assign fits     = !diff[DEN_W];
  assign quo_full = neg_q ? (~mag_q + NUM_W'(1)) : mag_q;
  assign quo_o    = quo_full[QUO_W-1:0];

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        if (step_q == STEP_W'(NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        step_q <= step_q + STEP_W'(1);
      end
    end
  end

  // Shift the magnitude left, bring each quotient bit in at the bottom
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[NUM_W-1];
      mag_q <= num_i[NUM_W-1] ? (~num_i + NUM_W'(1)) : num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      mag_q <= {mag_q[NUM_W-2:0], fits};
      rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

endmodule

>>> test/robust_moving_average_filter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// robust_moving_average_filter_tb
// Self-checking bench for the outlier-rejecting moving average filter.
// ----------------------------------------------------------------------------
// Sample items are driven on the input channel while a local copy of the
// three-slot window (samples, residuals, keep flags) predicts the smoothed
// value and the rejected flag of every accepted item. Each result taken from
// the output channel is compared field by field with the oldest prediction.
// The run covers field extremes, the zero-median cases, trust gains from
// zero to fifteen, long random speed traces with spikes and raw noise, random
// gaps on both channels, an output hold-off that fills the filter, and a
// sender pause until every result is back.
// ----------------------------------------------------------------------------
module robust_moving_average_filter_tb;
  import rmaf_pkg::*;

  localparam int     SW              = 32;
  localparam int     RW              = SW + 1;
  localparam int     CYCLE_LIMIT     = 1_000_000;
  localparam int     SETTLE_CYCLES   = 8;
  localparam int     TAIL_CYCLES     = 100;
  localparam int     HOLD_OFF_CYCLES = 300;
  localparam int     PHASE_ITEMS     = 165;
  localparam int     NOISE           = 1 << 14;
  localparam longint SMP_MAX         = 64'sd2147483647;
  localparam longint SMP_MIN         = -64'sd2147483648;
  localparam logic [APB_ADDR_W-1:0] TRUST_ADDR =
    {{(APB_ADDR_W-1){1'b0}}, REG_TRUST_GAIN} << REG_IDX_LSB;

  typedef struct packed {
    logic [SW-1:0] smoothed;
    logic          rejected;
  } filt_out_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  rmaf_in_if  #(.SAMPLE_WIDTH(SW)) smp_if ();
  rmaf_out_if #(.SAMPLE_WIDTH(SW)) avg_if ();

  robust_moving_average_filter #(
    .WINDOW      (3),
    .SAMPLE_WIDTH(SW)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (smp_if),
    .out_o  (avg_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // Local copy of the filter window and its trust setting
  longint                hist_smp  [3];
  logic [SW:0]           hist_res  [3];
  bit                    hist_keep [3];
  logic [TRUST_W-1:0]    trust_cfg;

  filt_out_t             smoothed_q [$];
  filt_out_t             due;
  longint                speed_level = 0;

  bit                    gaps_on    = 1'b1;
  int                    hold_left  = 0;
  int                    stall_left = 0;
  int                    n_items    = 0;
  int                    n_results  = 0;
  int                    n_rejected = 0;
  int                    n_err      = 0;
  int                    cycle_count;

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  // Mean of the kept window samples, truncated toward zero; zero if none kept.
  function automatic longint kept_mean();
    longint acc = 0;
    longint cnt = 0;
    for (int k = 0; k < 3; k++) begin
      if (hist_keep[k]) begin
        acc += hist_smp[k];
        cnt++;
      end
    end
    if (cnt == 0) cnt = 1;
    return acc / cnt;
  endfunction

  function automatic logic [SW:0] median3(logic [SW:0] a, logic [SW:0] b, logic [SW:0] c);
    logic [SW:0] lo;
    logic [SW:0] hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (c <= lo) return lo;
    if (c >= hi) return hi;
    return c;
  endfunction

  // Insert the sample, judge it against the median residual, emit the mean
  // of the kept slots and advance the window.
  function automatic filt_out_t predict_smoothed(logic [SW-1:0] raw);
    longint      s;
    longint      mean;
    longint      diff;
    logic [SW:0] res;
    logic [SW:0] med;
    filt_out_t   o;
    s            = $signed(raw);
    hist_smp[2]  = s;
    hist_keep[2] = 1'b1;
    mean         = kept_mean();
    diff         = s - mean;
    res          = RW'((diff < 0) ? -diff : diff);
    hist_res[2]  = res;
    med          = median3(hist_res[0], hist_res[1], hist_res[2]);
    o.rejected   = 64'(res) > 64'(trust_cfg) * 64'(med);
    hist_keep[2] = !o.rejected;
    mean         = kept_mean();
    o.smoothed   = mean[SW-1:0];
    for (int k = 0; k < 2; k++) begin
      hist_smp[k]  = hist_smp[k+1];
      hist_res[k]  = hist_res[k+1];
      hist_keep[k] = hist_keep[k+1];
    end
    hist_keep[2] = 1'b1;
    return o;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic longint clamp_sample(longint v);
    if (v > SMP_MAX) return SMP_MAX;
    if (v < SMP_MIN) return SMP_MIN;
    return v;
  endfunction

  // Speed trace: mostly a slow random walk with exact repeats, some spikes,
  // occasional jumps of the level and a little raw noise.
  function automatic logic [SW-1:0] next_speed();
    int     r;
    longint v;
    r = $urandom_range(0, 99);
    if (r < 5) return $urandom();
    if (r < 8) begin
      speed_level = $signed($urandom());
    end else if (r >= 30) begin
      speed_level = clamp_sample(speed_level + longint'($urandom_range(0, 2*NOISE)) - NOISE);
    end
    v = speed_level;
    if (r >= 8 && r < 20) begin
      v = clamp_sample(v + ((r % 2) ? 64'sd1 : -64'sd1) *
                       longint'($urandom_range(1 << 18, 1 << 30)));
    end
    return v[SW-1:0];
  endfunction

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(15, 60);
  endfunction

  function automatic void note_mismatch(string what, longint want, longint got);
    n_err++;
    if (n_err <= 10) begin
      $display("mismatch %s: expected %0d (0x%0h), got %0d (0x%0h)",
               what, want, want, got, got);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  task automatic apb_xfer(input bit wr, input logic [APB_ADDR_W-1:0] addr,
                          input logic [APB_DATA_W-1:0] wdata,
                          output logic [APB_DATA_W-1:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_trust_readback(logic [TRUST_W-1:0] want);
    logic [APB_DATA_W-1:0] rd;
    apb_xfer(1'b0, TRUST_ADDR, '0, rd);
    if (rd[TRUST_W-1:0] !== want) note_mismatch("trust gain readback", want, rd[TRUST_W-1:0]);
  endtask

  // Drop valid and wait until every predicted result has come back.
  task automatic wait_drained();
    @(negedge clk_i);
    smp_if.valid <= 1'b0;
    while (smoothed_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_trust(logic [TRUST_W-1:0] val);
    logic [APB_DATA_W-1:0] rd;
    wait_drained();
    apb_xfer(1'b1, TRUST_ADDR, APB_DATA_W'(val), rd);
    trust_cfg = val;
    check_trust_readback(val);
  endtask

  // Offer one item, record its prediction on acceptance, then idle a while.
  task automatic send_sample(logic [SW-1:0] raw);
    filt_out_t p;
    int        gap;
    @(negedge clk_i);
    smp_if.valid  <= 1'b1;
    smp_if.sample <= raw;
    do @(posedge clk_i); while (!smp_if.ready);
    p = predict_smoothed(raw);
    smoothed_q.push_back(p);
    n_items++;
    if (p.rejected) n_rejected++;
    gap = gap_len();
    repeat (gap) begin
      @(negedge clk_i);
      smp_if.valid  <= 1'b0;
      smp_if.sample <= $urandom();
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Reset trust value, zero-median cases and the sample extremes.
  task automatic test_reset_and_extremes();
    logic [SW-1:0] pts [13];
    check_trust_readback(TRUST_RESET);
    // zero residual on a zero median is kept, a nonzero one is rejected
    pts = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
            32'h0000_0001, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
            32'h8000_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
            32'h00A0_0000};
    foreach (pts[i]) send_sample(pts[i]);
  endtask

  // Tightest, loosest and zero trust gain on a steady trace with spikes.
  task automatic test_trust_corners();
    logic [TRUST_W-1:0] tf [3];
    tf = '{4'd1, 4'd15, 4'd0};
    foreach (tf[i]) begin
      write_trust(tf[i]);
      send_sample(32'h0001_0000);
      send_sample(32'h0001_0000);
      send_sample(32'h0004_0000);
      send_sample(32'hFFF0_0000);
    end
  endtask

  // Long random speed traces over several trust settings; one phase runs
  // without idling on either side.
  task automatic test_random_traffic();
    logic [TRUST_W-1:0] tf [6];
    tf = '{4'd1, 4'd15, 4'($urandom_range(1, 15)), 4'd0,
           4'($urandom_range(1, 15)), TRUST_RESET};
    foreach (tf[i]) begin
      write_trust(tf[i]);
      gaps_on = (i != 2);
      repeat (PHASE_ITEMS) send_sample(next_speed());
    end
    gaps_on = 1'b1;
  endtask

  // Hold the output off long enough that the filter fills and stalls input.
  task automatic test_output_hold_off();
    gaps_on   = 1'b0;
    hold_left = HOLD_OFF_CYCLES;
    repeat (12) send_sample(next_speed());
    gaps_on   = 1'b1;
  endtask

  // Pause the sender until every result is back, then resume.
  task automatic test_pause_until_drained();
    repeat (20) send_sample(next_speed());
    wait_drained();
    repeat (20) send_sample(next_speed());
  endtask

  // --------------------------------------------------------------------------
  // Result side: ready with random stalls, plus the hold-off countdown
  // --------------------------------------------------------------------------
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        avg_if.ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        avg_if.ready <= 1'b0;
        stall_left--;
      end else begin
        avg_if.ready <= 1'b1;
        stall_left = gap_len();
      end
    end
  end

  // Compare every accepted result with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && avg_if.valid && avg_if.ready) begin
      n_results++;
      if (smoothed_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) begin
          $display("unexpected result: smoothed 0x%0h rejected %0b",
                   avg_if.smoothed, avg_if.rejected);
        end
      end else begin
        due = smoothed_q.pop_front();
        if (avg_if.smoothed !== due.smoothed) begin
          note_mismatch("smoothed", $signed(due.smoothed), $signed(avg_if.smoothed));
        end
        if (avg_if.rejected !== due.rejected) begin
          note_mismatch("rejected", due.rejected, avg_if.rejected);
        end
      end
    end
  end

  // Cycle budget for the whole run.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results outstanding",
             cycle_count, smoothed_q.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    smp_if.valid  = 1'b0;
    smp_if.sample = '0;
    avg_if.ready  = 1'b0;
    rst_ni        = 1'b0;

    trust_cfg = TRUST_RESET;
    for (int k = 0; k < 3; k++) begin
      hist_smp[k]  = 0;
      hist_res[k]  = '0;
      hist_keep[k] = 1'b1;
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_and_extremes();
    test_trust_corners();
    test_random_traffic();
    test_output_hold_off();
    test_pause_until_drained();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("sent %0d samples, checked %0d results, %0d predicted outliers, %0d mismatches",
             n_items, n_results, n_rejected, n_err);
    $display("trust 0/1/6/15 and random, both-side stalls, output hold-off, drain pause");
    if (n_err == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
